@@ hw/rtl/dnid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnid_pkg
// Shared types and constants for the domain-to-node id allocator.
// ----------------------------------------------------------------------------
package dnid_pkg;

  localparam int DefDomainCount = 256;
  localparam int DefNodeCount   = 64;

  // forward entry: {mapped, node[5:0]}
  localparam int FwdW    = 7;
  localparam int NodeW   = 6;
  localparam int DomOutW = 8;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_LOOKUP  = 2'd1,
    KIND_REVERSE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage : dnid_pkg
`default_nettype wire

@@ hw/rtl/dnid_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : dnid_ram
`default_nettype wire

@@ hw/rtl/dnid_free_find.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnid_free_find
// Priority encoder: lowest clear bit of the node-in-use map.
// ----------------------------------------------------------------------------
module dnid_free_find #(
  parameter int N   = 64,
  localparam int NW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic [N-1:0]  used,
  output logic               found,
  output logic      [NW-1:0] idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        idx   = NW'(i);
      end
    end
  end

endmodule : dnid_free_find
`default_nettype wire

@@ hw/rtl/domain_to_node_id_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// domain_to_node_id_allocator
// First-fit node id allocator with forward (domain->node) and reverse
// (node->domain) maps held in RAM and an in-use bitmap in flops.
// ----------------------------------------------------------------------------
// Flow: the accept edge registers the RAM reads, then the result register
//   and any allocation writes are loaded once the output is free or draining.
//   A new item is accepted only after the current one has finished.
// Reset: rst clears control and the in-use map, then a clearing pass writes
//   max(DOMAIN_COUNT, NODE_COUNT) RAM entries, one per cycle, with
//   s_axis_tready low. Config writes are taken during the pass.
// ----------------------------------------------------------------------------
module domain_to_node_id_allocator
  import dnid_pkg::*;
#(
  parameter int DOMAIN_COUNT = DefDomainCount,
  parameter int NODE_COUNT   = DefNodeCount
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config: numa_disabled
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // domain_id[31:0], node_id[38:32], pad
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata   // node_out[5:0], node_valid[6],
                                          // domain_out[14:7], domain_valid[15]
);

  localparam int DW        = $clog2(DOMAIN_COUNT);
  localparam int NW        = $clog2(NODE_COUNT);
  localparam int RevW      = DW + 1;              // {valid, domain}
  localparam int ClrCount  = (DOMAIN_COUNT > NODE_COUNT) ? DOMAIN_COUNT : NODE_COUNT;
  localparam int CW        = $clog2(ClrCount);

  state_t state, state_next;

  logic          numa_disabled;
  logic [CW-1:0] clr_idx;
  logic [NODE_COUNT-1:0] used_bits;

  // captured request
  kind_t         req_kind;
  logic          req_dom_ok;     // in range and not disabled
  logic [DW-1:0] req_dom_idx;
  logic          req_node_ok;

  // output register
  logic        out_valid;
  logic [15:0] out_data;

  // RAM ports
  logic            fwd_we, fwd_re, rev_we, rev_re;
  logic [DW-1:0]   fwd_waddr, fwd_raddr;
  logic [FwdW-1:0] fwd_wdata, fwd_rdata;
  logic [NW-1:0]   rev_waddr, rev_raddr;
  logic [RevW-1:0] rev_wdata, rev_rdata;

  // free node search
  logic          free_found;
  logic [NW-1:0] free_idx;

  // decode of the incoming beat
  logic          in_fire;
  logic [31:0]   in_dom;
  logic [6:0]    in_node;
  logic          in_dom_range, in_node_ok;

  logic          finish;
  logic          do_alloc;
  logic [15:0]   result;

  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign in_dom       = s_axis_tdata[31:0];
  assign in_node      = s_axis_tdata[38:32];
  assign in_dom_range = (in_dom < 32'(DOMAIN_COUNT));
  assign in_node_ok   = !in_node[6] && (in_node < 7'(NODE_COUNT));

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  dnid_ram #(.WIDTH(FwdW), .DEPTH(DOMAIN_COUNT)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .re    (fwd_re),
    .raddr (fwd_raddr),
    .rdata (fwd_rdata)
  );

  dnid_ram #(.WIDTH(RevW), .DEPTH(NODE_COUNT)) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .waddr (rev_waddr),
    .wdata (rev_wdata),
    .re    (rev_re),
    .raddr (rev_raddr),
    .rdata (rev_rdata)
  );

  dnid_free_find #(.N(NODE_COUNT)) u_free_find (
    .used  (used_bits),
    .found (free_found),
    .idx   (free_idx)
  );

  // reads are issued on the accept edge; data is held until the next accept
  assign fwd_re    = in_fire;
  assign rev_re    = in_fire;
  assign fwd_raddr = in_dom_range ? in_dom[DW-1:0] : '0;
  assign rev_raddr = in_node_ok ? in_node[NW-1:0] : '0;

  // result may leave when the output register is free or being drained
  assign finish   = (state == ST_EXEC) && (!out_valid || m_axis_tready);
  // unmapped domain on allocate: take the lowest free node. A free node has
  // never been handed out, so its reverse entry is always invalid here.
  assign do_alloc = finish && (req_kind == KIND_ALLOC) && req_dom_ok &&
                    !fwd_rdata[FwdW-1] && free_found;

  // result assembly
  always_comb begin
    logic [NW+NodeW-1:0]  node_ext;
    logic [DW+DomOutW-1:0] dom_ext;
    node_ext = {{NodeW{1'b0}}, free_idx};
    dom_ext  = {{DomOutW{1'b0}}, rev_rdata[DW-1:0]};
    result   = '0;
    case (req_kind)
      KIND_ALLOC, KIND_LOOKUP: begin
        if (req_dom_ok) begin
          if (fwd_rdata[FwdW-1]) begin
            result[5:0] = fwd_rdata[NodeW-1:0];
            result[6]   = 1'b1;
          end else if (req_kind == KIND_ALLOC && free_found) begin
            result[5:0] = node_ext[NodeW-1:0];
            result[6]   = 1'b1;
          end
        end
      end
      KIND_REVERSE: begin
        if (req_node_ok && rev_rdata[RevW-1]) begin
          result[14:7] = dom_ext[DomOutW-1:0];
          result[15]   = 1'b1;
        end
      end
      default: result = '0;
    endcase
  end

  // write ports: clearing pass or allocation
  always_comb begin
    logic [NW+NodeW-1:0] node_ext;
    node_ext  = {{NodeW{1'b0}}, free_idx};
    fwd_we    = 1'b0;
    fwd_waddr = req_dom_idx;
    fwd_wdata = {1'b1, node_ext[NodeW-1:0]};
    rev_we    = 1'b0;
    rev_waddr = free_idx;
    rev_wdata = {1'b1, req_dom_idx};
    if (state == ST_CLEAR) begin
      fwd_we    = (32'(clr_idx) < 32'(DOMAIN_COUNT));
      fwd_waddr = clr_idx[DW-1:0];
      fwd_wdata = '0;
      rev_we    = (32'(clr_idx) < 32'(NODE_COUNT));
      rev_waddr = clr_idx[NW-1:0];
      rev_wdata = '0;
    end else if (do_alloc) begin
      fwd_we = 1'b1;
      rev_we = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == CW'(ClrCount - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_fire) state_next = ST_EXEC;
      ST_EXEC:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx       <= '0;
      numa_disabled <= 1'b0;
      used_bits     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_we) begin
        numa_disabled <= cfg_wdata;
      end
      if (do_alloc) begin
        used_bits[free_idx] <= 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind    <= kind_t'(s_axis_tuser);
      req_dom_ok  <= in_dom_range && !numa_disabled;
      req_dom_idx <= fwd_raddr;
      req_node_ok <= in_node_ok;
    end
    if (finish) begin
      out_data <= result;
    end
  end

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  a_used_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((used_bits & $past(used_bits)) == $past(used_bits)))
    else $error("node in-use bit dropped");

  a_maps_paired: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && fwd_we) |-> (rev_we && !used_bits[free_idx]))
    else $error("forward write without reverse write on a free node");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC))
    else $error("result beat without a processed item");

endmodule : domain_to_node_id_allocator
`default_nettype wire
